### design/ssf_pkg.sv
// ----------------------------------------------------------------------------
// ssf_pkg: shared types and constants of the state-space filter step
// Beat structs for both channels, opcodes, fixed-point widths and the tag
// and write-back records passed between the sequencer, the MAC and the top.
// ----------------------------------------------------------------------------
package ssf_pkg;

  // Default system order and the largest order the tag row width is sized for.
  localparam int DEFAULT_ORDER = 4;
  localparam int MAX_ORDER     = 8;

  // Q16.16 values, exact products rescaled by the fraction width.
  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = 2 * VALUE_W - FRAC_W;
  localparam int ROW_W   = $clog2(MAX_ORDER + 1);
  localparam int ACC_W   = PROD_W + ROW_W;

  // Saturation limits of a result value.
  localparam logic [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
  localparam logic [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

  // Item opcodes.
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_COEF   = 2'd1,
    OP_STATE  = 2'd2
  } op_t;

  // Input beat.
  typedef struct packed {
    logic [1:0]                op;
    logic [4:0]                index;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  // Output beat.
  typedef struct packed {
    logic signed [VALUE_W-1:0] output_y;
    logic                      saturated;
  } result_t;

  // One multiply-accumulate term as issued by the sequencer.
  // Row 0 is the output sum, row i+1 the sum of new state element i.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
  } tag_t;

  // A finished, saturated row sum.
  typedef struct packed {
    logic                      valid;
    logic [ROW_W-1:0]          row;
    logic signed [VALUE_W-1:0] value;
    logic                      sat;
  } wb_t;

endpackage

### design/state_space_filter_step_top.sv
// ----------------------------------------------------------------------------
// state_space_filter_step_top: discrete SISO state-space system step
// Coefficients and the state vector live in RAMs; one shared MAC works
// through y = C.x + D.u and x' = A.x + B.u a term at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid, item_stall, item) carries three kinds of
//   beat: a sample (op 0), a coefficient write (op 1) and a state element
//   write (op 2). Out-of-range writes and op 3 are taken and dropped.
//   The result channel (result_valid, result_stall, result) returns one beat
//   per sample: output y and a flag that is set if y or any new state
//   element clipped.
//   A sample issues (ORDER+1)^2 terms, one per cycle on the single
//   multiplier; the next item is taken only after the result has been
//   handed to the output register.
//   The new state is written to the second half of the state RAM, and the
//   halves swap when the last row is done.
//   While a result waits on result_stall the block finishes the sample and
//   then holds item_stall high until the output register takes the result.
//   Reset clears per-entry valid bits so both stores read as zero; there is
//   no clearing pass, and an item can be taken in the first cycle after it.
// ----------------------------------------------------------------------------
module state_space_filter_step_top #(
  parameter int ORDER = ssf_pkg::DEFAULT_ORDER
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ssf_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output ssf_pkg::result_t result
);
  import ssf_pkg::*;

  localparam int NCOEF  = ORDER * ORDER + 2 * ORDER + 1;
  localparam int CA_W   = $clog2(NCOEF);
  localparam int SIDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int SA_W   = SIDX_W + 1;
  localparam int SDEPTH = 1 << SA_W;

  logic                      item_go;
  logic                      sample_go;
  logic                      coef_we;
  logic                      host_st_we;
  logic                      wb_we;
  logic                      st_we;
  logic [CA_W-1:0]           coef_waddr;
  logic [SA_W-1:0]           st_waddr;
  logic [SA_W-1:0]           st_raddr;
  logic [VALUE_W-1:0]        st_wdata;
  logic [VALUE_W-1:0]        coef_rd;
  logic [VALUE_W-1:0]        st_rd;
  logic signed [VALUE_W-1:0] coef_op;
  logic signed [VALUE_W-1:0] x_op;
  logic [NCOEF-1:0]          coef_vld;
  logic [SDEPTH-1:0]         st_vld;
  logic                      cv_q;
  logic                      sv_q;
  logic                      bank;
  logic signed [VALUE_W-1:0] u;
  logic signed [VALUE_W-1:0] y_hold;
  logic                      sat_any;
  logic                      seq_idle;
  logic                      deliver;
  logic                      out_free;
  logic                      mac_done;
  logic [CA_W-1:0]           caddr;
  logic [SIDX_W-1:0]         sidx;
  tag_t                      issue;
  wb_t                       wb;

  // Items are taken only between samples.
  assign item_stall = !seq_idle;
  assign item_go    = item_valid && !item_stall;
  assign sample_go  = item_go && (item.op == OP_SAMPLE);
  assign coef_we    = item_go && (item.op == OP_COEF) && (int'(item.index) < NCOEF);
  assign host_st_we = item_go && (item.op == OP_STATE) && (int'(item.index) < ORDER);
  assign coef_waddr = CA_W'(item.index);

  // Write-back of a state row goes to the inactive half of the state RAM.
  assign wb_we    = wb.valid && (wb.row != '0);
  assign mac_done = wb.valid && (wb.row == ROW_W'(ORDER));
  assign st_we    = host_st_we || wb_we;
  assign st_waddr = wb_we ? {~bank, SIDX_W'(wb.row - 1'b1)} : {bank, SIDX_W'(item.index)};
  assign st_wdata = wb_we ? wb.value : item.value;
  assign st_raddr = {bank, sidx};

  assign out_free = !result_valid || !result_stall;

  ssf_seq #(
    .ORDER (ORDER)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (sample_go),
    .done     (mac_done),
    .out_free (out_free),
    .idle     (seq_idle),
    .deliver  (deliver),
    .issue    (issue),
    .caddr    (caddr),
    .sidx     (sidx)
  );

  ssf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (NCOEF)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (item.value),
    .raddr (caddr),
    .rdata (coef_rd)
  );

  ssf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SDEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rd)
  );

  // Valid bits: an entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      st_vld   <= '0;
    end else begin
      if (coef_we) begin
        coef_vld[coef_waddr] <= 1'b1;
      end
      if (st_we) begin
        st_vld[st_waddr] <= 1'b1;
      end
    end
  end

  // Valid bits are looked up with the same latency as the RAM data.
  always_ff @(posedge clk) begin
    cv_q <= coef_vld[caddr];
    sv_q <= st_vld[st_raddr];
  end

  assign coef_op = cv_q ? signed'(coef_rd) : '0;
  assign x_op    = sv_q ? signed'(st_rd) : '0;

  ssf_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .coef  (coef_op),
    .xval  (x_op),
    .u     (u),
    .wb    (wb)
  );

  // Active state half swaps once the whole new state has been written.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (mac_done) begin
      bank <= ~bank;
    end
  end

  // Sample input, output row and clip flag of the sample in progress.
  always_ff @(posedge clk) begin
    if (sample_go) begin
      u       <= item.value;
      sat_any <= 1'b0;
    end else if (wb.valid && wb.sat) begin
      sat_any <= 1'b1;
    end
    if (wb.valid && (wb.row == '0)) begin
      y_hold <= wb.value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (deliver) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      result.output_y  <= y_hold;
      result.saturated <= sat_any;
    end
  end

  // Row sums only come back while a sample is in progress.
  a_wb_busy: assert property (@(posedge clk) disable iff (rst)
    wb.valid |-> !seq_idle)
    else $error("row write-back while the sequencer is idle");

  // Host state writes and row write-back never share the write port.
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(host_st_we && wb_we))
    else $error("state RAM write port claimed twice");

  // A delivered sample shows up on the result channel.
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    deliver |=> result_valid)
    else $error("delivered result did not reach the output register");

  // The state halves swap only at the end of a sample.
  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    (bank != $past(bank)) |-> ($past(mac_done) || $past(rst)))
    else $error("state half swapped outside the end of a sample");

endmodule

### design/ssf_ram.sv
// ----------------------------------------------------------------------------
// ssf_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ssf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Registered read. A read of the entry being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ssf_seq.sv
// ----------------------------------------------------------------------------
// ssf_seq: term sequencer
// Walks the rows and columns of one sample, one term per cycle, and drives
// the coefficient and state read addresses; then waits for the last row to
// be written back and for the output register to take the result.
// ----------------------------------------------------------------------------
module ssf_seq #(
  parameter int ORDER   = ssf_pkg::DEFAULT_ORDER,
  localparam int NCOEF  = ORDER * ORDER + 2 * ORDER + 1,
  localparam int CA_W   = $clog2(NCOEF),
  localparam int SIDX_W = (ORDER > 1) ? $clog2(ORDER) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              done,
  input  logic              out_free,
  output logic              idle,
  output logic              deliver,
  output ssf_pkg::tag_t     issue,
  output logic [CA_W-1:0]   caddr,
  output logic [SIDX_W-1:0] sidx
);
  import ssf_pkg::*;

  localparam int OFS_B = ORDER * ORDER;
  localparam int OFS_C = OFS_B + ORDER;
  localparam int OFS_D = OFS_C + ORDER;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_DELIVER
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic             col_end;
  logic             row_end;

  assign col_end = (col == ROW_W'(ORDER));
  assign row_end = (row == ROW_W'(ORDER));

  // Sequencer state and term counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      col   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          row <= '0;
          col <= '0;
          if (start) begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (col_end) begin
            col <= '0;
            if (row_end) begin
              state <= S_DRAIN;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end
        S_DRAIN: begin
          if (done) begin
            state <= S_DELIVER;
          end
        end
        S_DELIVER: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle    = (state == S_IDLE);
  assign deliver = (state == S_DELIVER) && out_free;

  // Tag of the term issued this cycle. Column 0 multiplies by the input.
  always_comb begin
    issue.valid = (state == S_ISSUE);
    issue.first = (col == '0);
    issue.last  = col_end;
    issue.row   = row;
  end

  // Coefficient address: D and C for the output row, B and A for state rows.
  always_comb begin
    if (row == '0) begin
      if (col == '0) begin
        caddr = CA_W'(OFS_D);
      end else begin
        caddr = CA_W'(OFS_C + int'(col) - 1);
      end
    end else begin
      if (col == '0) begin
        caddr = CA_W'(OFS_B + int'(row) - 1);
      end else begin
        caddr = CA_W'((int'(row) - 1) * ORDER + int'(col) - 1);
      end
    end
  end

  // State element read alongside columns 1 and up.
  assign sidx = SIDX_W'(col - 1'b1);

endmodule

### design/ssf_mac.sv
// ----------------------------------------------------------------------------
// ssf_mac: shared multiply-accumulate unit
// Multiplies a coefficient by a state element or the input sample, rescales
// by the fraction width with floor, sums a row exactly and saturates it.
// ----------------------------------------------------------------------------
module ssf_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  ssf_pkg::tag_t                      issue,
  input  logic signed [ssf_pkg::VALUE_W-1:0] coef,
  input  logic signed [ssf_pkg::VALUE_W-1:0] xval,
  input  logic signed [ssf_pkg::VALUE_W-1:0] u,
  output ssf_pkg::wb_t                       wb
);
  import ssf_pkg::*;

  tag_t                        t1;
  tag_t                        t2;
  tag_t                        t3;
  logic signed [VALUE_W-1:0]   b_op;
  logic signed [2*VALUE_W-1:0] full;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_next;
  logic [ACC_W-VALUE_W:0]      top_bits;
  logic                        clip;

  // Tags follow the data: t1 lines up with the RAM read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
    end else begin
      t1 <= issue;
      t2 <= t1;
      t3 <= t2;
    end
  end

  // Multiply stage. An arithmetic drop of the low bits is the floor rescale.
  assign b_op = t1.first ? u : xval;
  assign full = coef * b_op;

  always_ff @(posedge clk) begin
    if (t1.valid) begin
      prod <= full[2*VALUE_W-1:FRAC_W];
    end
  end

  // Accumulate stage. The first term of a row restarts the sum.
  assign acc_next = (t2.first ? {ACC_W{1'b0}} : acc)
                  + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (t2.valid) begin
      acc <= acc_next;
    end
  end

  // Saturate a finished row: it fits when the bits above the value agree.
  assign top_bits = acc[ACC_W-1:VALUE_W-1];
  assign clip     = !((top_bits == '0) || (top_bits == '1));

  always_comb begin
    wb.valid = t3.valid && t3.last;
    wb.row   = t3.row;
    wb.sat   = clip;
    if (!clip) begin
      wb.value = acc[VALUE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      wb.value = Q_MIN;
    end else begin
      wb.value = Q_MAX;
    end
  end

endmodule
